### sv/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 RGB median filter.
package mf3_pkg;

	localparam int CFG_W          = 12;
	localparam int COORD_W        = 11;
	localparam int CH_W           = 8;
	localparam int PIX_W          = 3 * CH_W;
	localparam int WIN_N          = 3;
	localparam int WIN_TAPS       = WIN_N * WIN_N;
	localparam int SIZE_LIMIT     = 2048;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int REG_IDX_W      = 1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [CFG_W-1:0] SIZE_MIN     = 12'd3;
	localparam logic [CFG_W-1:0] SIZE_TOP     = 12'(SIZE_LIMIT);

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [PIX_W-1:0] rgb_t;
	typedef rgb_t  [WIN_TAPS-1:0] rgb_win_t;
	typedef chan_t [WIN_TAPS-1:0] chan_win_t;

	typedef struct packed {
		logic [CH_W-1:0] pixel_blue;
		logic [CH_W-1:0] pixel_green;
		logic [CH_W-1:0] pixel_red;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0]    median_blue;
		logic [CH_W-1:0]    median_green;
		logic [CH_W-1:0]    median_red;
		logic [COORD_W-1:0] window_row;
		logic [COORD_W-1:0] window_col;
		logic               frame_done;
	} result_t;

	// Position tag that travels alongside a window through the lanes.
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               done;
	} tag_t;

	function automatic chan_t min2(input chan_t a, input chan_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic chan_t max2(input chan_t a, input chan_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// Clamp a size register to 3..top.
	function automatic logic [CFG_W-1:0] bound_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] top);
		logic [CFG_W-1:0] r;
		r = (v > top) ? top : v;
		if (r < SIZE_MIN) begin
			r = SIZE_MIN;
		end
		return r;
	endfunction

endpackage

### sv/mf3_line_window.sv
// Raster counters, two line stores and the 3x3 RGB window register.
module mf3_line_window #(
	parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         take,
	input  mf3_pkg::rgb_t                pix,
	input  logic [mf3_pkg::CFG_W-1:0]    width_eff,
	input  logic [mf3_pkg::CFG_W-1:0]    height_eff,
	output mf3_pkg::rgb_win_t            win,
	output logic                         win_valid,
	output mf3_pkg::tag_t                win_tag
);

	localparam int DEPTH = (MAX_WIDTH < mf3_pkg::SIZE_LIMIT) ? MAX_WIDTH : mf3_pkg::SIZE_LIMIT;
	localparam int AW    = $clog2(DEPTH);

	mf3_pkg::rgb_t store_a [DEPTH];
	mf3_pkg::rgb_t store_b [DEPTH];

	logic [mf3_pkg::COORD_W-1:0] col_q, row_q;
	logic [mf3_pkg::CFG_W-1:0]   col_next, row_next;
	logic [AW-1:0]               addr;

	logic                        valid_s1, emit_s1, done_s1;
	logic [AW-1:0]               addr_s1;
	logic [mf3_pkg::COORD_W-1:0] row_s1, col_s1;
	mf3_pkg::rgb_t               pix_s1, above_s1, above2_s1;

	mf3_pkg::rgb_win_t           win_q;
	logic                        win_valid_q;
	mf3_pkg::tag_t               tag_q;

	assign col_next = {1'b0, col_q} + 12'd1;
	assign row_next = {1'b0, row_q} + 12'd1;
	assign addr     = col_q[AW-1:0];

	// Advance the raster position on each accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (col_next >= width_eff) begin
				col_q <= '0;
				if (row_next >= height_eff) begin
					row_q <= '0;
				end else begin
					row_q <= row_next[mf3_pkg::COORD_W-1:0];
				end
			end else begin
				col_q <= col_next[mf3_pkg::COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			above_s1  <= store_a[addr];
			above2_s1 <= store_b[addr];
			pix_s1    <= pix;
			addr_s1   <= addr;
			row_s1    <= row_q;
			col_s1    <= col_q;
			emit_s1   <= (row_q >= 11'd2) && (col_q >= 11'd2);
			done_s1   <= (row_next == height_eff) && (col_next == width_eff);
		end
	end

	// Write back: the row above moves down one store, the new pixel takes its place.
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			store_b[addr_s1] <= above_s1;
			store_a[addr_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			for (int r = 0; r < mf3_pkg::WIN_N; r++) begin
				win_q[r*3+0] <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= above2_s1;
			win_q[5] <= above_s1;
			win_q[8] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
		end else if (en) begin
			win_valid_q <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			tag_q.row  <= row_s1 - 11'd2;
			tag_q.col  <= col_s1 - 11'd2;
			tag_q.done <= done_s1;
		end
	end

	assign win       = win_q;
	assign win_valid = win_valid_q;
	assign win_tag   = tag_q;

endmodule

### sv/mf3_median_lane.sv
// Two-stage median-of-nine network for one 8-bit color channel.
module mf3_median_lane (
	input  logic                clk,
	input  logic                en,
	input  mf3_pkg::chan_win_t  win,
	output mf3_pkg::chan_t      med
);

	mf3_pkg::chan_t lo_s1  [3];
	mf3_pkg::chan_t mid_s1 [3];
	mf3_pkg::chan_t hi_s1  [3];
	mf3_pkg::chan_t med_s2;

	// Sort each window column.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				lo_s1[c]  <= mf3_pkg::min2(mf3_pkg::min2(win[c], win[3+c]), win[6+c]);
				mid_s1[c] <= mf3_pkg::med3(win[c], win[3+c], win[6+c]);
				hi_s1[c]  <= mf3_pkg::max2(mf3_pkg::max2(win[c], win[3+c]), win[6+c]);
			end
		end
	end

	// Median = med(max of lows, med of mids, min of highs).
	always_ff @(posedge clk) begin
		if (en) begin
			med_s2 <= mf3_pkg::med3(
				mf3_pkg::max2(mf3_pkg::max2(lo_s1[0], lo_s1[1]), lo_s1[2]),
				mf3_pkg::med3(mid_s1[0], mid_s1[1], mid_s1[2]),
				mf3_pkg::min2(mf3_pkg::min2(hi_s1[0], hi_s1[1]), hi_s1[2]));
		end
	end

	assign med = med_s2;

endmodule

### sv/median_filter_3x3_rgb_top.sv
// Top level of the streaming 3x3 RGB median filter.
//
// Pixels enter in raster order on the pixel channel (valid/ready), one per
// transaction. Once a pixel completes a full 3x3 window (row and column both
// at least 2) the block sends one transaction on the result channel: the
// median of the nine values of each color, the window's top-left row and
// column, and frame_done on the last window of the frame. Border pixels
// produce nothing. Image size comes from the write port (cfg_we, cfg_index,
// cfg_data) and is clamped to 3..2048 and to MAX_WIDTH; write it only idle.
// Throughput is one pixel per clock while the skid entry is free, set by the
// single read and write port of each line store and the fully pipelined
// compare networks. A result passes through the line store read, window, two
// compare stages and output register on its way to the outputs.
// Reset clears the counters and all valid flags and loads 640x480; line
// stores are not cleared. When the receiver stalls, the output register
// holds and a one-entry skid register catches the next result; pixel_ready
// drops only while that skid entry is full, freezing the whole pipeline.
module median_filter_3x3_rgb_top #(
	parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pixel_valid,
	output logic                            pixel_ready,
	input  mf3_pkg::pixel_t                 pixel,
	output logic                            result_valid,
	input  logic                            result_ready,
	output mf3_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [mf3_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mf3_pkg::CFG_W-1:0]       cfg_data
);

	localparam int WIDTH_TOP = (MAX_WIDTH < mf3_pkg::SIZE_LIMIT) ? MAX_WIDTH : mf3_pkg::SIZE_LIMIT;

	logic [mf3_pkg::CFG_W-1:0] width_q, height_q, width_eff, height_eff;

	logic                en, take;
	mf3_pkg::rgb_t       pix;
	mf3_pkg::rgb_win_t   win;
	logic                win_valid;
	mf3_pkg::tag_t       win_tag;

	mf3_pkg::chan_win_t  win_b, win_g, win_r;
	mf3_pkg::chan_t      med_b, med_g, med_r;

	logic                valid_s3, valid_s4;
	mf3_pkg::tag_t       tag_s3, tag_s4;
	mf3_pkg::result_t    merged;

	logic                out_valid_q, skid_valid_q;
	mf3_pkg::result_t    out_q, skid_q;
	logic                push;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf3_pkg::WIDTH_RESET;
			height_q <= mf3_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mf3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				mf3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign width_eff  = mf3_pkg::bound_size(width_q, 12'(WIDTH_TOP));
	assign height_eff = mf3_pkg::bound_size(height_q, mf3_pkg::SIZE_TOP);

	// Advance the pipeline whenever the skid entry is free.
	assign en          = !skid_valid_q;
	assign pixel_ready = en;
	assign take        = pixel_valid && en;
	assign pix         = {pixel.pixel_red, pixel.pixel_green, pixel.pixel_blue};

	mf3_line_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.take       (take),
		.pix        (pix),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.win        (win),
		.win_valid  (win_valid),
		.win_tag    (win_tag)
	);

	// Split the window into one byte-wide window per color lane.
	always_comb begin
		for (int i = 0; i < mf3_pkg::WIN_TAPS; i++) begin
			win_b[i] = win[i][7:0];
			win_g[i] = win[i][15:8];
			win_r[i] = win[i][23:16];
		end
	end

	mf3_median_lane u_lane_blue  (.clk(clk), .en(en), .win(win_b), .med(med_b));
	mf3_median_lane u_lane_green (.clk(clk), .en(en), .win(win_g), .med(med_g));
	mf3_median_lane u_lane_red   (.clk(clk), .en(en), .win(win_r), .med(med_r));

	// Carry the valid flag and position tag in step with the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= win_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= win_tag;
			tag_s4 <= tag_s3;
		end
	end

	// Merge the three lane medians with the tag into one result.
	always_comb begin
		merged.median_blue  = med_b;
		merged.median_green = med_g;
		merged.median_red   = med_r;
		merged.window_row   = tag_s4.row;
		merged.window_col   = tag_s4.col;
		merged.frame_done   = tag_s4.done;
	end

	assign push = valid_s4 && en;

	// Output register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= merged;
			end
		end else if (push) begin
			skid_q <= merged;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### sim/testbench.sv
// Self-checking testbench for the streaming 3x3 RGB median filter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DUT_MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF;
	localparam int WIDTH_TOP     = (DUT_MAX_WIDTH < mf3_pkg::SIZE_LIMIT) ?
		DUT_MAX_WIDTH : mf3_pkg::SIZE_LIMIT;
	localparam int IDLE_PCT      = 23;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 120;
	localparam int RANDOM_ITEMS  = 460;
	localparam int REPORT_LIMIT  = 10;
	localparam int CYCLE_LIMIT   = 400000;

	typedef logic [mf3_pkg::COORD_W-1:0] coord_t;
	typedef logic [mf3_pkg::CFG_W-1:0]   cfg_word_t;

	// Predicts the filter's output from each accepted pixel and checks the
	// results against the oldest pending prediction.
	class median_board;
		mf3_pkg::rgb_t line_a [WIDTH_TOP];
		mf3_pkg::rgb_t line_b [WIDTH_TOP];
		mf3_pkg::rgb_t win [mf3_pkg::WIN_TAPS];
		cfg_word_t width_reg;
		cfg_word_t height_reg;
		int unsigned row_n;
		int unsigned col_n;
		mf3_pkg::result_t pending_medians [$];
		int unsigned failures;

		function new();
			width_reg = mf3_pkg::WIDTH_RESET;
			height_reg = mf3_pkg::HEIGHT_RESET;
			row_n = 0;
			col_n = 0;
			failures = 0;
			foreach (win[i]) win[i] = '0;
			foreach (line_a[i]) begin
				line_a[i] = '0;
				line_b[i] = '0;
			end
		endfunction

		function void load_reg(logic [mf3_pkg::REG_IDX_W-1:0] idx, cfg_word_t val);
			if (idx == mf3_pkg::REG_IMAGE_WIDTH) begin
				width_reg = val;
			end else begin
				height_reg = val;
			end
		endfunction

		function int unsigned clamp_size(cfg_word_t v, int unsigned top);
			int unsigned s;
			s = v;
			if (s > top) s = top;
			if (s < 3) s = 3;
			return s;
		endfunction

		// Median of one color across the nine taps, by insertion sort.
		function mf3_pkg::chan_t median_of(int unsigned shift);
			mf3_pkg::chan_t v [mf3_pkg::WIN_TAPS];
			mf3_pkg::chan_t x;
			int j;
			for (int i = 0; i < mf3_pkg::WIN_TAPS; i++) begin
				x = mf3_pkg::chan_t'(win[i] >> shift);
				j = i;
				while (j > 0 && v[j-1] > x) begin
					v[j] = v[j-1];
					j--;
				end
				v[j] = x;
			end
			return v[mf3_pkg::WIN_TAPS / 2];
		endfunction

		function void take_pixel(mf3_pkg::pixel_t p);
			int unsigned w;
			int unsigned h;
			int unsigned col_idx;
			mf3_pkg::rgb_t fresh;
			mf3_pkg::rgb_t up1;
			mf3_pkg::rgb_t up2;
			mf3_pkg::result_t r;
			w = clamp_size(width_reg, WIDTH_TOP);
			h = clamp_size(height_reg, mf3_pkg::SIZE_LIMIT);
			fresh = {p.pixel_red, p.pixel_green, p.pixel_blue};
			col_idx = (col_n < WIDTH_TOP) ? col_n : WIDTH_TOP - 1;
			up1 = line_a[col_idx];
			up2 = line_b[col_idx];
			line_b[col_idx] = up1;
			line_a[col_idx] = fresh;
			for (int k = 0; k < mf3_pkg::WIN_N; k++) begin
				win[k*mf3_pkg::WIN_N]     = win[k*mf3_pkg::WIN_N + 1];
				win[k*mf3_pkg::WIN_N + 1] = win[k*mf3_pkg::WIN_N + 2];
			end
			win[2] = up2;
			win[5] = up1;
			win[8] = fresh;
			if (row_n >= 2 && col_n >= 2) begin
				r.median_blue  = median_of(0);
				r.median_green = median_of(mf3_pkg::CH_W);
				r.median_red   = median_of(2 * mf3_pkg::CH_W);
				r.window_row   = coord_t'(row_n - 2);
				r.window_col   = coord_t'(col_n - 2);
				r.frame_done   = (row_n == h - 1) && (col_n == w - 1);
				pending_medians = {pending_medians, r};
			end
			col_n++;
			if (col_n >= w) begin
				col_n = 0;
				row_n++;
				if (row_n >= h) row_n = 0;
			end
		endfunction

		function void check_median(mf3_pkg::result_t got);
			mf3_pkg::result_t want;
			bit bad;
			if (pending_medians.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("unexpected result: b %0d g %0d r %0d row %0d col %0d done %0b",
						got.median_blue, got.median_green, got.median_red,
						got.window_row, got.window_col, got.frame_done);
				end
				return;
			end
			want = pending_medians.pop_front();
			bad = (got.median_blue !== want.median_blue)
				|| (got.median_green !== want.median_green)
				|| (got.median_red !== want.median_red)
				|| (got.window_row !== want.window_row)
				|| (got.window_col !== want.window_col)
				|| (got.frame_done !== want.frame_done);
			if (bad) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("mismatch: expected b %0d g %0d r %0d row %0d col %0d done %0b",
						want.median_blue, want.median_green, want.median_red,
						want.window_row, want.window_col, want.frame_done);
					$display("          actual   b %0d g %0d r %0d row %0d col %0d done %0b",
						got.median_blue, got.median_green, got.median_red,
						got.window_row, got.window_col, got.frame_done);
				end
			end
		endfunction

		function int unsigned pending();
			return pending_medians.size();
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n       = 1'b0;
	logic                                pixel_valid  = 1'b0;
	logic                                pixel_ready;
	mf3_pkg::pixel_t                     pixel        = '0;
	logic                                result_valid;
	logic                                result_ready = 1'b0;
	mf3_pkg::result_t                    result;
	logic                                cfg_we       = 1'b0;
	logic [mf3_pkg::REG_IDX_W-1:0]       cfg_index    = mf3_pkg::REG_IMAGE_WIDTH;
	cfg_word_t                           cfg_data     = '0;

	median_board     board = new();
	mf3_pkg::pixel_t pixel_q [$];
	bit              pixel_busy = 1'b0;  // a pixel transaction is on offer
	bit              calm = 1'b0;        // suppress random idling on both sides
	bit              hold_req = 1'b0;    // ask the receiver for one long hold-off
	int unsigned     cycle_count = 0;

	median_filter_3x3_rgb_top #(
		.MAX_WIDTH(DUT_MAX_WIDTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Pixel sender: offer queued pixels, idling now and then between
	// transactions; hold valid and payload until the transaction completes.
	initial begin : pixel_sender
		forever begin
			@(posedge clk);
			if (pixel_valid && pixel_ready) begin
				board.take_pixel(pixel);
				pixel_busy = 1'b0;
			end
			if (!pixel_busy) begin
				if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					pixel <= pixel_q.pop_front();
					pixel_valid <= 1'b1;
					pixel_busy = 1'b1;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: check every completed transaction, stall at random,
	// and on request hold ready low long enough to back the pipeline up.
	initial begin : result_receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				board.check_median(result);
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				result_ready <= 1'b0;
			end else begin
				result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: end the run if it goes far past the slowest legal run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic write_reg(input logic [mf3_pkg::REG_IDX_W-1:0] idx, input cfg_word_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.load_reg(idx, val);
	endtask

	task automatic set_size(input cfg_word_t w_val, input cfg_word_t h_val);
		write_reg(mf3_pkg::REG_IMAGE_WIDTH, w_val);
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, h_val);
	endtask

	// Favor the channel extremes so ties and saturated medians show up often.
	function automatic mf3_pkg::chan_t rand_chan();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return mf3_pkg::chan_t'($urandom_range(3));
			default: return mf3_pkg::chan_t'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_pixels(input int unsigned n);
		mf3_pkg::pixel_t p;
		repeat (n) begin
			p.pixel_blue  = rand_chan();
			p.pixel_green = rand_chan();
			p.pixel_red   = rand_chan();
			pixel_q = {pixel_q, p};
		end
	endtask

	// Wait until every pixel is sent and every result is in, then let the
	// pipeline flush pixels that produce no result.
	task automatic wait_idle();
		while (pixel_q.size() != 0 || pixel_busy || board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : main_sequence
		mf3_pkg::pixel_t corner_px [9];
		int unsigned random_sent;
		int unsigned w_eff;
		int unsigned h_eff;
		cfg_word_t w_val;
		cfg_word_t h_val;
		int phase;

		corner_px = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'h808080, 24'h7F7F7F, 24'h01FE55, 24'hAAAAAA};
		random_sent = 0;
		phase = 0;

		// Hold reset, then release it on a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame, with both sizes below range: one window, frame_done set.
		set_size(12'd0, 12'd2);
		foreach (corner_px[i]) pixel_q = {pixel_q, corner_px[i]};
		wait_idle();

		// Shrink the width while the column is past the new bound, then the
		// height while the row is past it; both wrap at the end of the row.
		set_size(12'd4, 12'd4);
		queue_pixels(11);
		wait_idle();
		write_reg(mf3_pkg::REG_IMAGE_WIDTH, 12'd3);
		queue_pixels(2);
		wait_idle();
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 12'd3);
		queue_pixels(2);
		wait_idle();

		// Random frames; the first runs under a long receiver hold-off, the
		// second with no idling on either side.
		while (random_sent < RANDOM_ITEMS) begin
			if (phase == 0) begin
				w_val = 12'd12;
				h_val = 12'd6;
			end else if (phase == 1) begin
				w_val = 12'd16;
				h_val = 12'd6;
			end else begin
				w_val = cfg_word_t'($urandom_range(10));
				h_val = cfg_word_t'($urandom_range(7));
			end
			w_eff = (w_val < 3) ? 3 : w_val;
			h_eff = (h_val < 3) ? 3 : h_val;
			set_size(w_val, h_val);
			calm = (phase == 1);
			queue_pixels(2 * w_eff * h_eff);
			random_sent += 2 * w_eff * h_eff;
			if (phase == 0) hold_req = 1'b1;
			wait_idle();
			calm = 1'b0;
			phase++;
		end

		// Width register above range clamps to 2048: start a wide row, then
		// shrink the width past the column and finish a 3x3 frame.
		set_size(12'hFFF, 12'd3);
		queue_pixels(6);
		wait_idle();
		write_reg(mf3_pkg::REG_IMAGE_WIDTH, 12'd3);
		queue_pixels(7);
		wait_idle();

		// Height register above range: run past row 2, then shrink the height
		// and let the row wrap to the start of the frame.
		set_size(12'd3, 12'hFFF);
		queue_pixels(9);
		wait_idle();
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 12'd3);
		queue_pixels(3);
		wait_idle();

		// Back to a small full frame.
		set_size(12'd5, 12'd4);
		queue_pixels(20);
		wait_idle();

		if (board.failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
sv/mf3_pkg.sv
sv/mf3_line_window.sv
sv/mf3_median_lane.sv
sv/median_filter_3x3_rgb_top.sv
sim/testbench.sv
